// ===== src/ffra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants
// Status and request codes, state and shift types, defaults of the allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int DefMaxFreeRanges = 16;
    localparam int DefAddrWidth     = 32;
    localparam int PortAddrWidth    = 32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // Shift action broadcast to the cell row.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_LEFT,
        SH_RIGHT
    } shift_t;

endpackage

// ===== src/ffra_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_cell: one table entry
// Holds one free range and takes a neighbor's entry on a shift, or a local
// write from the controller.
// ----------------------------------------------------------------------------
module ffra_cell #(
    parameter int AW = 32
) (
    input  logic          clk,
    input  logic          shl,
    input  logic          shr,
    input  logic [AW-1:0] left_start,
    input  logic [AW-1:0] left_end,
    input  logic          left_mode,
    input  logic [AW-1:0] right_start,
    input  logic [AW-1:0] right_end,
    input  logic          right_mode,
    input  logic          wr_start,
    input  logic          wr_end,
    input  logic          wr_all,
    input  logic [AW-1:0] wdata_start,
    input  logic [AW-1:0] wdata_end,
    input  logic          wdata_mode,
    output logic [AW-1:0] cell_start,
    output logic [AW-1:0] cell_end,
    output logic          cell_mode
);

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] end_reg, end_next;
    logic          mode_reg, mode_next;

    // Select the neighbor entry on a shift; a local write overrides it.
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        mode_next  = mode_reg;
        if (shl)
        begin
            start_next = right_start;
            end_next   = right_end;
            mode_next  = right_mode;
        end
        else if (shr)
        begin
            start_next = left_start;
            end_next   = left_end;
            mode_next  = left_mode;
        end
        if (wr_all || wr_start)
            start_next = wdata_start;
        if (wr_all || wr_end)
            end_next = wdata_end;
        if (wr_all)
            mode_next = wdata_mode;
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        mode_reg  <= mode_next;
    end

    assign cell_start = start_reg;
    assign cell_end   = end_reg;
    assign cell_mode  = mode_reg;

endmodule

// ===== src/first_fit_region_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator: first-fit free-range table with coalescing
// Steps: a request is accepted in idle, the scan state passes over entries
// until the decision, a shift state follows when the row of cells shifts,
// and the done state then raises the result.
// One word at a time: the next word is held off until its result is taken.
// Reset clears the fill count and the controller; entries are not cleared.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
    parameter int MAX_FREE_RANGES = ffra_pkg::DefMaxFreeRanges,
    parameter int ADDR_WIDTH      = ffra_pkg::DefAddrWidth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] alloc_size,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    input  logic        range_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] granted_start,
    output logic [31:0] granted_end,
    output logic        granted_mode
);
    import ffra_pkg::*;

    localparam int N  = MAX_FREE_RANGES;
    localparam int AW = ADDR_WIDTH;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int PW = PortAddrWidth;

    // Cell row signals.
    logic [AW-1:0] c_start [N];
    logic [AW-1:0] c_end   [N];
    logic          c_mode  [N];
    logic [N-1:0]  shl_v, shr_v;

    // Control registers.
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    shift_t        sh_reg, sh_next;
    logic          type_reg;
    logic [AW-1:0] a_reg, b_reg;
    logic          m_reg;
    logic          ov_reg, ov_next;
    logic [1:0]    st_reg, st_next;
    logic [PW-1:0] gs_reg, gs_next, ge_reg, ge_next;
    logic          gm_reg, gm_next;

    // Local write controls.
    logic [IW-1:0] wr_idx;
    logic          wr_start, wr_end, wr_all;
    logic [AW-1:0] wd_start, wd_end;
    logic          wd_mode;

    // Scan read of the current cell and its predecessor.
    logic [IW-1:0] pidx, qidx;
    logic [AW-1:0] cur_s, cur_e, prv_e, span, gsum;
    logic          cur_m, prv_m, at_end, has_prev;
    logic          mnext, mprev;

    assign pidx     = pos_reg[IW-1:0];
    assign qidx     = pidx - IW'(1);
    assign cur_s    = c_start[pidx];
    assign cur_e    = c_end[pidx];
    assign cur_m    = c_mode[pidx];
    assign prv_e    = c_end[qidx];
    assign prv_m    = c_mode[qidx];
    assign at_end   = (pos_reg >= count_reg);
    assign has_prev = (pos_reg != '0);
    assign span     = cur_e - cur_s;
    assign gsum     = cur_s + a_reg;
    assign mnext    = !at_end && (b_reg == cur_s) && (m_reg == cur_m);
    assign mprev    = has_prev && (prv_e == a_reg) && (m_reg == prv_m);

    // A waiting result word holds off the next request.
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && !ov_reg)
                    state_next = S_SCAN;
            S_SCAN:
                if (at_end || (type_reg == REQ_FREE && !(cur_s < a_reg)) ||
                    (type_reg == REQ_ALLOC && cur_s <= cur_e && a_reg <= span))
                    state_next = (sh_next != SH_NONE) ? S_SHIFT : S_DONE;
                else if (type_reg == REQ_FREE && a_reg >= b_reg)
                    state_next = S_DONE;
            S_SHIFT:
                state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Scan decisions and datapath outputs.
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        sh_next    = SH_NONE;
        st_next    = st_reg;
        gs_next    = gs_reg;
        ge_next    = ge_reg;
        gm_next    = gm_reg;
        ov_next    = ov_reg && out_stall;
        wr_idx     = pidx;
        wr_start   = 1'b0;
        wr_end     = 1'b0;
        wr_all     = 1'b0;
        wd_start   = a_reg;
        wd_end     = b_reg;
        wd_mode    = m_reg;
        case (state_reg)
            S_IDLE:
            begin
                pos_next = '0;
                // The result word is cleared only when a new request is taken.
                if (in_valid && !ov_reg)
                begin
                    st_next = ST_OK;
                    gs_next = '0;
                    ge_next = '0;
                    gm_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (type_reg == REQ_FREE && a_reg >= b_reg)
                    st_next = ST_EMPTY;
                else if (type_reg == REQ_ALLOC)
                begin
                    if (at_end)
                        st_next = ST_NOFIT;
                    else if (cur_s <= cur_e && a_reg <= span)
                    begin
                        gs_next = PW'(cur_s);
                        ge_next = PW'(gsum);
                        gm_next = cur_m;
                        if (a_reg < span)
                        begin
                            wr_start = 1'b1;
                            wd_start = gsum;
                        end
                        else
                            sh_next = SH_LEFT;
                    end
                    else
                        pos_next = pos_reg + CW'(1);
                end
                else if (at_end || !(cur_s < a_reg))
                begin
                    if (mnext && mprev)
                    begin
                        wr_idx   = qidx;
                        wr_end   = 1'b1;
                        wd_end   = cur_e;
                        sh_next  = SH_LEFT;
                    end
                    else if (mnext)
                        wr_start = 1'b1;
                    else if (mprev)
                    begin
                        wr_idx = qidx;
                        wr_end = 1'b1;
                    end
                    else if (count_reg >= CW'(N))
                        st_next = ST_FULL;
                    else
                        sh_next = SH_RIGHT;
                end
                else
                    pos_next = pos_reg + CW'(1);
            end
            S_SHIFT:
            begin
                if (sh_reg == SH_LEFT)
                    count_next = count_reg - CW'(1);
                else
                begin
                    count_next = count_reg + CW'(1);
                    wr_all     = 1'b1;
                end
            end
            S_DONE:
                ov_next = 1'b1;
            default:
                ;
        endcase
    end

    // Shift masks: a left shift moves cells at and above the position, a right shift those above it.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            shl_v[i] = (state_reg == S_SHIFT) && (sh_reg == SH_LEFT) &&
                       (CW'(i) >= pos_reg);
            shr_v[i] = (state_reg == S_SHIFT) && (sh_reg == SH_RIGHT) &&
                       (CW'(i) > pos_reg);
        end
    end

    // Row of cells.
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == N - 1) ? N - 1 : g + 1;
        logic hit;
        assign hit = (wr_idx == IW'(g));
        ffra_cell #(.AW(AW)) u_cell (
            .clk         (clk),
            .shl         (shl_v[g]),
            .shr         (shr_v[g]),
            .left_start  (c_start[L]),
            .left_end    (c_end[L]),
            .left_mode   (c_mode[L]),
            .right_start (c_start[R]),
            .right_end   (c_end[R]),
            .right_mode  (c_mode[R]),
            .wr_start    (hit && wr_start),
            .wr_end      (hit && wr_end),
            .wr_all      (hit && wr_all),
            .wdata_start (wd_start),
            .wdata_end   (wd_end),
            .wdata_mode  (wd_mode),
            .cell_start  (c_start[g]),
            .cell_end    (c_end[g]),
            .cell_mode   (c_mode[g])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        sh_reg  <= (state_reg == S_SCAN) ? sh_next : sh_reg;
        st_reg  <= st_next;
        gs_reg  <= gs_next;
        ge_reg  <= ge_next;
        gm_reg  <= gm_next;
        if (state_reg == S_IDLE && in_valid && !ov_reg)
        begin
            type_reg <= req_type;
            a_reg    <= (req_type == REQ_ALLOC) ? AW'(alloc_size) : AW'(range_start);
            b_reg    <= AW'(range_end);
            m_reg    <= range_mode;
        end
    end

    assign status        = st_reg;
    assign granted_start = gs_reg;
    assign granted_end   = ge_reg;
    assign granted_mode  = gm_reg;

endmodule
